FILE: rtl/core/dpdt_pkg.sv
`default_nettype none

package dpdt_pkg;

   // field widths
   localparam int unsigned OP_W    = 2;
   localparam int unsigned REG_W   = 3;
   localparam int unsigned DATA_W  = 32;
   localparam int unsigned CTL_W   = 8;
   localparam int unsigned PRESC_W = 8;

   // number of timer slots addressable by the select bit
   localparam int unsigned TIMER_SLOTS = 2;

   // operation codes
   localparam logic [OP_W-1:0] OP_TICK  = 2'd0;
   localparam logic [OP_W-1:0] OP_READ  = 2'd1;
   localparam logic [OP_W-1:0] OP_WRITE = 2'd2;

   // register word indexes
   localparam logic [REG_W-1:0] REG_LOAD   = 3'd0;
   localparam logic [REG_W-1:0] REG_VALUE  = 3'd1;
   localparam logic [REG_W-1:0] REG_CTRL   = 3'd2;
   localparam logic [REG_W-1:0] REG_CLEAR  = 3'd3;
   localparam logic [REG_W-1:0] REG_RAW    = 3'd4;
   localparam logic [REG_W-1:0] REG_MASKED = 3'd5;
   localparam logic [REG_W-1:0] REG_BGLOAD = 3'd6;

   // control bit positions
   localparam int unsigned CTL_ENABLE   = 7;
   localparam int unsigned CTL_PERIODIC = 6;
   localparam int unsigned CTL_INTEN    = 5;
   localparam int unsigned CTL_PRE_HI   = 3;
   localparam int unsigned CTL_PRE_LO   = 2;
   localparam int unsigned CTL_WIDE     = 1;
   localparam int unsigned CTL_ONESHOT  = 0;

   localparam logic [CTL_W-1:0] CTL_WRITABLE = 8'hEF;
   localparam logic [CTL_W-1:0] CTL_RESET    = 8'h20;

   // prescaler codes and their last count
   localparam logic [1:0] PRE_DIV16  = 2'd1;
   localparam logic [1:0] PRE_DIV256 = 2'd2;
   localparam logic [PRESC_W-1:0] PRESC_LAST16  = 8'd15;
   localparam logic [PRESC_W-1:0] PRESC_LAST256 = 8'd255;

   localparam logic [DATA_W-1:0] MASK_NARROW = 32'h0000_FFFF;
   localparam logic [DATA_W-1:0] MASK_WIDE   = 32'hFFFF_FFFF;

   // command from the item stage to one timer
   typedef struct packed {
      logic                tick;
      logic                write;
      logic [REG_W-1:0]    reg_index;
      logic [DATA_W-1:0]   data;
   } cmd_type;

   // what one timer reports back
   typedef struct packed {
      logic [DATA_W-1:0]   read_data;
      logic                irq;
   } status_type;

endpackage

`default_nettype wire

FILE: rtl/core/dpdt_timer.sv
`default_nettype none

module dpdt_timer (
   input  wire logic               clock,
   input  wire logic               reset,
   input  wire dpdt_pkg::cmd_type  cmd,
   output      dpdt_pkg::status_type status
);

   logic [dpdt_pkg::DATA_W-1:0]  load_ff,  load_in;
   logic [dpdt_pkg::DATA_W-1:0]  count_ff, count_in;
   logic [dpdt_pkg::CTL_W-1:0]   ctl_ff,   ctl_in;
   logic                         raw_ff,   raw_in;
   logic [dpdt_pkg::PRESC_W-1:0] presc_ff, presc_in;

   logic [dpdt_pkg::DATA_W-1:0]  width_mask;
   logic [dpdt_pkg::DATA_W-1:0]  cur;
   logic [dpdt_pkg::PRESC_W-1:0] presc_last;
   logic [1:0]                   pre_code;
   logic [dpdt_pkg::DATA_W-1:0]  read_word;

   // width and prescaler decode from current control
   assign pre_code   = ctl_ff[dpdt_pkg::CTL_PRE_HI:dpdt_pkg::CTL_PRE_LO];
   assign width_mask = ctl_ff[dpdt_pkg::CTL_WIDE] ? dpdt_pkg::MASK_WIDE
                                                  : dpdt_pkg::MASK_NARROW;
   assign cur        = count_ff & width_mask;

   always_comb begin
      case (pre_code)
         dpdt_pkg::PRE_DIV16:  presc_last = dpdt_pkg::PRESC_LAST16;
         dpdt_pkg::PRE_DIV256: presc_last = dpdt_pkg::PRESC_LAST256;
         default:              presc_last = '0;
      endcase
   end

   // next state for a tick or a register write
   always_comb begin
      load_in  = load_ff;
      count_in = count_ff;
      ctl_in   = ctl_ff;
      raw_in   = raw_ff;
      presc_in = presc_ff;
      if (cmd.tick && ctl_ff[dpdt_pkg::CTL_ENABLE]) begin
         if (presc_ff < presc_last) begin
            presc_in = presc_ff + 1'b1;
         end else begin
            presc_in = '0;
            if (cur == '0) begin
               if (ctl_ff[dpdt_pkg::CTL_ONESHOT]) begin
                  count_in = '0;
               end else if (ctl_ff[dpdt_pkg::CTL_PERIODIC]) begin
                  count_in = load_ff & width_mask;
               end else begin
                  count_in = width_mask;
               end
            end else begin
               count_in = (cur - 1'b1) & width_mask;
               if (cur == dpdt_pkg::DATA_W'(1)) begin
                  raw_in = 1'b1;
               end
            end
         end
      end else if (cmd.write) begin
         unique case (cmd.reg_index)
            dpdt_pkg::REG_LOAD: begin
               load_in  = cmd.data;
               count_in = cmd.data;
               presc_in = '0;
            end
            dpdt_pkg::REG_CTRL: begin
               ctl_in = cmd.data[dpdt_pkg::CTL_W-1:0] & dpdt_pkg::CTL_WRITABLE;
            end
            dpdt_pkg::REG_CLEAR: begin
               raw_in = 1'b0;
            end
            dpdt_pkg::REG_BGLOAD: begin
               load_in = cmd.data;
            end
            default: begin
            end
         endcase
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         load_ff  <= '0;
         count_ff <= dpdt_pkg::MASK_WIDE;
         ctl_ff   <= dpdt_pkg::CTL_RESET;
         raw_ff   <= 1'b0;
         presc_ff <= '0;
      end else begin
         load_ff  <= load_in;
         count_ff <= count_in;
         ctl_ff   <= ctl_in;
         raw_ff   <= raw_in;
         presc_ff <= presc_in;
      end
   end

   // register read from the state before the item
   always_comb begin
      unique case (cmd.reg_index) inside
         dpdt_pkg::REG_LOAD,
         dpdt_pkg::REG_BGLOAD: read_word = load_ff;
         dpdt_pkg::REG_VALUE:  read_word = cur;
         dpdt_pkg::REG_CTRL:   read_word = dpdt_pkg::DATA_W'(ctl_ff);
         dpdt_pkg::REG_RAW:    read_word = dpdt_pkg::DATA_W'(raw_ff);
         dpdt_pkg::REG_MASKED: read_word =
            dpdt_pkg::DATA_W'(raw_ff & ctl_ff[dpdt_pkg::CTL_INTEN]);
         default:              read_word = '0;
      endcase
   end

   // interrupt as it stands after the item
   assign status = '{
      read_data: read_word,
      irq:       raw_in & ctl_in[dpdt_pkg::CTL_INTEN]
   };

endmodule

`default_nettype wire

FILE: rtl/core/dual_periodic_down_timer.sv
// Dual periodic down timer with two identical counters behind a register map.
// Every transfer on the req channel is one item: a clock tick, a register
// read, a register write or a no-op (op 3), with op, timer select and register
// index in req_tuser and the write data in req_tdata. Every item gives exactly one
// transfer on the rsp channel carrying read data (zero unless a read) and the
// masked interrupts of both timers as they stand after the item.
// An accepted item waits in the input register, where the result is formed,
// until the result register is free; that register then takes the result,
// the timers update at the same edge and rsp_tvalid rises. Throughput is one
// item per cycle while the receiver does not stall: the timer update is a single
// decrement and compare per counter, done as the item leaves the input register.
// While the receiver stalls, the result register holds its item and the
// input register holds the next; req_tready drops only when both are full.
// Reset clears both stages and puts each timer at load 0, value all ones,
// control with only interrupt enable set, status and prescaler at zero.
// NUM_TIMERS selects how many timers exist; an absent timer reads as zero,
// ignores writes and never interrupts.
`default_nettype none

module dual_periodic_down_timer #(
   parameter int unsigned NUM_TIMERS = 2
) (
   input  wire logic        clock,
   input  wire logic        reset,
   // request channel
   input  wire logic        req_tvalid,
   output      logic        req_tready,
   input  wire logic [31:0] req_tdata,   // write_data[31:0]
   input  wire logic [5:0]  req_tuser,   // op[1:0], timer_select[2], reg_index[5:3]
   // response channel
   output      logic        rsp_tvalid,
   input  wire logic        rsp_tready,
   output      logic [39:0] rsp_tdata    // read_data[31:0], irq_first[32],
                                         // irq_second[33], irq_any[34], zero[39:35]
);

   localparam int unsigned OUT_W = 40;

   // input stage
   logic                          in_valid_ff, in_valid_in;
   logic [dpdt_pkg::OP_W-1:0]     in_op_ff;
   logic                          in_sel_ff;
   logic [dpdt_pkg::REG_W-1:0]    in_reg_ff;
   logic [dpdt_pkg::DATA_W-1:0]   in_data_ff;

   // result stage
   logic                          out_valid_ff, out_valid_in;
   logic [OUT_W-1:0]              out_data_ff, out_data_in;

   logic                          in_fire;
   logic                          stage_fire;
   logic                          out_free;

   dpdt_pkg::cmd_type             cmd    [dpdt_pkg::TIMER_SLOTS];
   dpdt_pkg::status_type          status [dpdt_pkg::TIMER_SLOTS];

   logic [dpdt_pkg::DATA_W-1:0]   read_data;
   logic                          irq_first;
   logic                          irq_second;

   // handshake
   assign out_free   = !out_valid_ff || rsp_tready;
   assign stage_fire = in_valid_ff && out_free;
   assign req_tready = !in_valid_ff || out_free;
   assign in_fire    = req_tvalid && req_tready;

   assign in_valid_in  = in_fire || (in_valid_ff && !stage_fire);
   assign out_valid_in = stage_fire || (out_valid_ff && !rsp_tready);

   always_ff @(posedge clock) begin
      if (reset) begin
         in_valid_ff  <= 1'b0;
         out_valid_ff <= 1'b0;
      end else begin
         in_valid_ff  <= in_valid_in;
         out_valid_ff <= out_valid_in;
      end
   end

   // payload registers
   always_ff @(posedge clock) begin
      if (in_fire) begin
         in_op_ff   <= req_tuser[1:0];
         in_sel_ff  <= req_tuser[2];
         in_reg_ff  <= req_tuser[5:3];
         in_data_ff <= req_tdata;
      end
      if (stage_fire) begin
         out_data_ff <= out_data_in;
      end
   end

   // timers, absent slots tied off
   for (genvar k = 0; k < dpdt_pkg::TIMER_SLOTS; k++) begin : g_timer
      assign cmd[k] = '{
         tick:      stage_fire && (in_op_ff == dpdt_pkg::OP_TICK),
         write:     stage_fire && (in_op_ff == dpdt_pkg::OP_WRITE)
                    && (in_sel_ff == 1'(k)),
         reg_index: in_reg_ff,
         data:      in_data_ff
      };
      if (k < NUM_TIMERS) begin : g_present
         dpdt_timer u_timer (
            .clock  (clock),
            .reset  (reset),
            .cmd    (cmd[k]),
            .status (status[k])
         );
      end else begin : g_absent
         assign status[k] = '0;
      end
   end

   // result formation
   assign read_data  = (in_op_ff == dpdt_pkg::OP_READ) ? status[in_sel_ff].read_data : '0;
   assign irq_first  = status[0].irq;
   assign irq_second = status[1].irq;

   assign out_data_in = {5'b0, irq_first | irq_second, irq_second, irq_first, read_data};

   assign rsp_tvalid = out_valid_ff;
   assign rsp_tdata  = out_data_ff;

endmodule

`default_nettype wire

FILE: tb/tb.sv
`timescale 1ns / 100ps

module tb;

   // codes the package leaves unnamed
   localparam logic [dpdt_pkg::OP_W-1:0]  OP_NOP     = 2'd3;
   localparam logic [dpdt_pkg::REG_W-1:0] REG_UNUSED = 3'd7;
   localparam logic [1:0]       PRE_DIV1     = 2'd0;
   localparam logic [1:0]       PRE_DIV1_ALT = 2'd3;

   // control register bits
   localparam logic [dpdt_pkg::CTL_W-1:0] BIT_ENABLE   = 8'h01 << dpdt_pkg::CTL_ENABLE;
   localparam logic [dpdt_pkg::CTL_W-1:0] BIT_PERIODIC = 8'h01 << dpdt_pkg::CTL_PERIODIC;
   localparam logic [dpdt_pkg::CTL_W-1:0] BIT_INTEN    = 8'h01 << dpdt_pkg::CTL_INTEN;
   localparam logic [dpdt_pkg::CTL_W-1:0] BIT_WIDE     = 8'h01 << dpdt_pkg::CTL_WIDE;
   localparam logic [dpdt_pkg::CTL_W-1:0] BIT_ONESHOT  = 8'h01 << dpdt_pkg::CTL_ONESHOT;

   localparam int RSP_W          = 40;
   localparam int HOLD_CYCLES    = 300;
   localparam int WATCHDOG_LIMIT = 2000;
   localparam int MAX_REPORTS    = 40;

   typedef struct packed {
      logic [dpdt_pkg::DATA_W-1:0] read_data;
      logic                        irq_first;
      logic                        irq_second;
      logic                        irq_any;
   } timer_out_type;

   logic             clock      = 1'b0;
   logic             reset      = 1'b1;
   logic             req_tvalid = 1'b0;
   logic             req_tready;
   logic [31:0]      req_tdata  = '0;   // write_data[31:0]
   logic [5:0]       req_tuser  = '0;   // op[1:0], timer_select[2], reg_index[5:3]
   logic             rsp_tvalid;
   logic             rsp_tready = 1'b0;
   logic [RSP_W-1:0] rsp_tdata;         // read_data[31:0], irq_first[32],
                                        // irq_second[33], irq_any[34]

   // mirrored timer state
   logic [dpdt_pkg::DATA_W-1:0]  load_reg  [dpdt_pkg::TIMER_SLOTS];
   logic [dpdt_pkg::DATA_W-1:0]  count_reg [dpdt_pkg::TIMER_SLOTS];
   logic [dpdt_pkg::CTL_W-1:0]   ctrl_reg  [dpdt_pkg::TIMER_SLOTS];
   logic                         raw_flag  [dpdt_pkg::TIMER_SLOTS];
   logic [dpdt_pkg::PRESC_W-1:0] presc_reg [dpdt_pkg::TIMER_SLOTS];

   timer_out_type timer_outputs_q [$];

   int error_count      = 0;
   int items_sent       = 0;
   int rsp_seen         = 0;
   int rsp_wait_left    = 0;
   int idle_cycles      = 0;
   bit no_idle          = 1'b0;
   bit hold_off_request = 1'b0;

   dual_periodic_down_timer dut (
      .clock      (clock),
      .reset      (reset),
      .req_tvalid (req_tvalid),
      .req_tready (req_tready),
      .req_tdata  (req_tdata),
      .req_tuser  (req_tuser),
      .rsp_tvalid (rsp_tvalid),
      .rsp_tready (rsp_tready),
      .rsp_tdata  (rsp_tdata)
   );

   always begin
      #10 clock = 1'b1;
      #10 clock = 1'b0;
   end

   // counting width of a timer
   function automatic logic [dpdt_pkg::DATA_W-1:0] count_mask(int t);
      return ctrl_reg[t][dpdt_pkg::CTL_WIDE] ? dpdt_pkg::MASK_WIDE : dpdt_pkg::MASK_NARROW;
   endfunction

   // one tick through the prescaler and the down counter
   function automatic void tick_one(int t);
      logic [dpdt_pkg::PRESC_W-1:0] last;
      logic [dpdt_pkg::DATA_W-1:0]  m;
      logic [dpdt_pkg::DATA_W-1:0]  cur;
      if (!ctrl_reg[t][dpdt_pkg::CTL_ENABLE]) return;
      case (ctrl_reg[t][dpdt_pkg::CTL_PRE_HI:dpdt_pkg::CTL_PRE_LO])
         dpdt_pkg::PRE_DIV16: begin
            last = dpdt_pkg::PRESC_LAST16;
         end
         dpdt_pkg::PRE_DIV256: begin
            last = dpdt_pkg::PRESC_LAST256;
         end
         default: begin
            last = '0;
         end
      endcase
      if (presc_reg[t] < last) begin
         presc_reg[t] = presc_reg[t] + 1'b1;
         return;
      end
      presc_reg[t] = '0;
      m   = count_mask(t);
      cur = count_reg[t] & m;
      if (cur == '0) begin
         if (ctrl_reg[t][dpdt_pkg::CTL_ONESHOT])
            count_reg[t] = '0;
         else if (ctrl_reg[t][dpdt_pkg::CTL_PERIODIC])
            count_reg[t] = load_reg[t] & m;
         else
            count_reg[t] = m;
      end else begin
         count_reg[t] = (cur - 1) & m;
         if (cur == 1) raw_flag[t] = 1'b1;
      end
   endfunction

   // apply one item to the mirrored timers and form its response
   function automatic timer_out_type advance_timers(logic [dpdt_pkg::OP_W-1:0] op,
                                                    logic sel,
                                                    logic [dpdt_pkg::REG_W-1:0] idx,
                                                    logic [dpdt_pkg::DATA_W-1:0] data);
      timer_out_type res;
      int            t;
      res = '0;
      case (op)
         dpdt_pkg::OP_TICK: begin
            for (t = 0; t < dpdt_pkg::TIMER_SLOTS; t++) tick_one(t);
         end
         dpdt_pkg::OP_READ: begin
            case (idx) inside
               dpdt_pkg::REG_LOAD, dpdt_pkg::REG_BGLOAD: res.read_data = load_reg[sel];
               dpdt_pkg::REG_VALUE: res.read_data = count_reg[sel] & count_mask(sel);
               dpdt_pkg::REG_CTRL:  res.read_data = dpdt_pkg::DATA_W'(ctrl_reg[sel]);
               dpdt_pkg::REG_RAW:   res.read_data = dpdt_pkg::DATA_W'(raw_flag[sel]);
               dpdt_pkg::REG_MASKED: begin
                  res.read_data = dpdt_pkg::DATA_W'(raw_flag[sel]
                                                    & ctrl_reg[sel][dpdt_pkg::CTL_INTEN]);
               end
               default:             res.read_data = '0;
            endcase
         end
         dpdt_pkg::OP_WRITE: begin
            case (idx)
               dpdt_pkg::REG_LOAD: begin
                  load_reg[sel]  = data;
                  count_reg[sel] = data;
                  presc_reg[sel] = '0;
               end
               dpdt_pkg::REG_CTRL: begin
                  ctrl_reg[sel] = data[dpdt_pkg::CTL_W-1:0] & dpdt_pkg::CTL_WRITABLE;
               end
               dpdt_pkg::REG_CLEAR:  raw_flag[sel] = 1'b0;
               dpdt_pkg::REG_BGLOAD: load_reg[sel] = data;
               default: ;
            endcase
         end
         default: ;
      endcase
      res.irq_first  = raw_flag[0] & ctrl_reg[0][dpdt_pkg::CTL_INTEN];
      res.irq_second = raw_flag[1] & ctrl_reg[1][dpdt_pkg::CTL_INTEN];
      res.irq_any    = res.irq_first | res.irq_second;
      return res;
   endfunction

   task automatic report_mismatch(string what, logic [dpdt_pkg::DATA_W-1:0] got,
                                  logic [dpdt_pkg::DATA_W-1:0] want);
      error_count++;
      if (error_count <= MAX_REPORTS)
         $display("mismatch on %s at response %0d: got %h, expected %h",
                  what, rsp_seen, got, want);
   endtask

   task automatic check_response(logic [RSP_W-1:0] word);
      timer_out_type got;
      timer_out_type want;
      got.read_data  = word[31:0];
      got.irq_first  = word[32];
      got.irq_second = word[33];
      got.irq_any    = word[34];
      rsp_seen++;
      if (timer_outputs_q.size() == 0) begin
         report_mismatch("response with none pending", got.read_data, '0);
         return;
      end
      want = timer_outputs_q.pop_front();
      if (got.read_data !== want.read_data)
         report_mismatch("read_data", got.read_data, want.read_data);
      if (got.irq_first !== want.irq_first)
         report_mismatch("irq_first", dpdt_pkg::DATA_W'(got.irq_first),
                         dpdt_pkg::DATA_W'(want.irq_first));
      if (got.irq_second !== want.irq_second)
         report_mismatch("irq_second", dpdt_pkg::DATA_W'(got.irq_second),
                         dpdt_pkg::DATA_W'(want.irq_second));
      if (got.irq_any !== want.irq_any)
         report_mismatch("irq_any", dpdt_pkg::DATA_W'(got.irq_any),
                         dpdt_pkg::DATA_W'(want.irq_any));
   endtask

   // one item on the request channel, with a random gap in front
   task automatic send_item(logic [dpdt_pkg::OP_W-1:0] op, logic sel,
                            logic [dpdt_pkg::REG_W-1:0] idx,
                            logic [dpdt_pkg::DATA_W-1:0] data);
      int gap;
      gap = no_idle ? 0 : $urandom_range(0, 6);
      if (gap > 0) begin
         req_tvalid <= 1'b0;
         repeat (gap) @(posedge clock);
      end
      req_tvalid <= 1'b1;
      req_tdata  <= data;
      req_tuser  <= {idx, sel, op};
      do @(posedge clock); while (!req_tready);
      timer_outputs_q.push_back(advance_timers(op, sel, idx, data));
      if (op != OP_NOP &&
          !(op == dpdt_pkg::OP_WRITE && idx inside {dpdt_pkg::REG_VALUE, dpdt_pkg::REG_RAW,
                                                    dpdt_pkg::REG_MASKED, REG_UNUSED}))
         items_sent++;
   endtask

   // response side: check each transfer, then stall at random
   always @(posedge clock) begin
      if (!reset && rsp_tvalid && rsp_tready) check_response(rsp_tdata);
      if (hold_off_request) begin
         hold_off_request = 1'b0;
         rsp_wait_left    = HOLD_CYCLES;
      end else if (rsp_tvalid && rsp_tready) begin
         rsp_wait_left = no_idle ? 0 : $urandom_range(0, 6);
      end else if (rsp_wait_left > 0) begin
         rsp_wait_left--;
      end
      rsp_tready <= !reset && rsp_wait_left == 0;
   end

   // watchdog on cycles without any transfer
   always @(posedge clock) begin
      if ((req_tvalid && req_tready) || (rsp_tvalid && rsp_tready)) begin
         idle_cycles <= 0;
      end else if (idle_cycles == WATCHDOG_LIMIT) begin
         $display("** dual_periodic_down_timer: FAILED **");
         $finish;
      end else begin
         idle_cycles <= idle_cycles + 1;
      end
   end

   // reset values, reserved control bit, ignored writes, unused codes
   task automatic test_register_map();
      send_item(dpdt_pkg::OP_READ, 1'b0, dpdt_pkg::REG_CTRL, '0);
      send_item(dpdt_pkg::OP_READ, 1'b1, dpdt_pkg::REG_VALUE, '0);
      send_item(dpdt_pkg::OP_WRITE, 1'b1, dpdt_pkg::REG_CTRL, '1);
      send_item(dpdt_pkg::OP_READ, 1'b1, dpdt_pkg::REG_CTRL, '0);
      send_item(dpdt_pkg::OP_WRITE, 1'b1, dpdt_pkg::REG_CTRL,
                dpdt_pkg::DATA_W'(dpdt_pkg::CTL_RESET));
      send_item(dpdt_pkg::OP_WRITE, 1'b0, dpdt_pkg::REG_VALUE, '1);
      send_item(dpdt_pkg::OP_WRITE, 1'b0, dpdt_pkg::REG_RAW, '1);
      send_item(dpdt_pkg::OP_WRITE, 1'b0, dpdt_pkg::REG_MASKED, '1);
      send_item(dpdt_pkg::OP_WRITE, 1'b1, REG_UNUSED, '1);
      send_item(dpdt_pkg::OP_READ, 1'b0, REG_UNUSED, '0);
      send_item(OP_NOP, 1'b1, REG_UNUSED, '1);
      send_item(dpdt_pkg::OP_WRITE, 1'b0, dpdt_pkg::REG_BGLOAD, '1);
      send_item(dpdt_pkg::OP_READ, 1'b0, dpdt_pkg::REG_LOAD, '0);
      send_item(dpdt_pkg::OP_READ, 1'b1, dpdt_pkg::REG_CLEAR, '0);
   endtask

   // oneshot over periodic, periodic reload, free-running wrap
   task automatic test_expiry_modes();
      send_item(dpdt_pkg::OP_WRITE, 1'b0, dpdt_pkg::REG_LOAD, 32'd1);
      send_item(dpdt_pkg::OP_WRITE, 1'b0, dpdt_pkg::REG_CTRL,
                dpdt_pkg::DATA_W'(BIT_ENABLE | BIT_INTEN | BIT_ONESHOT | BIT_PERIODIC));
      send_item(dpdt_pkg::OP_TICK, 1'b0, dpdt_pkg::REG_LOAD, '0);
      send_item(dpdt_pkg::OP_TICK, 1'b1, dpdt_pkg::REG_LOAD, '0);
      send_item(dpdt_pkg::OP_READ, 1'b0, dpdt_pkg::REG_MASKED, '0);
      send_item(dpdt_pkg::OP_WRITE, 1'b0, dpdt_pkg::REG_CLEAR, '0);
      send_item(dpdt_pkg::OP_WRITE, 1'b0, dpdt_pkg::REG_CTRL,
                dpdt_pkg::DATA_W'(BIT_ENABLE | BIT_PERIODIC | BIT_WIDE));
      send_item(dpdt_pkg::OP_WRITE, 1'b0, dpdt_pkg::REG_BGLOAD, 32'd2);
      repeat (3) send_item(dpdt_pkg::OP_TICK, 1'b0, dpdt_pkg::REG_LOAD, '0);
      send_item(dpdt_pkg::OP_READ, 1'b0, dpdt_pkg::REG_RAW, '0);
      send_item(dpdt_pkg::OP_WRITE, 1'b0, dpdt_pkg::REG_CTRL,
                dpdt_pkg::DATA_W'(BIT_ENABLE
                                  | (dpdt_pkg::CTL_W'(PRE_DIV1_ALT) << dpdt_pkg::CTL_PRE_LO)));
      send_item(dpdt_pkg::OP_TICK, 1'b0, dpdt_pkg::REG_LOAD, '0);
      send_item(dpdt_pkg::OP_READ, 1'b0, dpdt_pkg::REG_VALUE, '0);
   endtask

   // mostly load / control / tick sequences with random content, some noise
   task automatic test_random_traffic(int target);
      logic [1:0]                  pre;
      logic [dpdt_pkg::CTL_W-1:0]  ctrl;
      logic [dpdt_pkg::DATA_W-1:0] start;
      logic                        sel;
      int                          pick;
      int                          steps;
      while (items_sent < target) begin
         sel = 1'($urandom_range(0, 1));
         if ($urandom_range(0, 3) == 0) begin
            send_item(dpdt_pkg::OP_W'($urandom_range(0, 3)), 1'($urandom_range(0, 1)),
                      dpdt_pkg::REG_W'($urandom_range(0, 7)), $urandom);
         end else begin
            start = ($urandom_range(0, 3) == 0) ? $urandom : $urandom_range(0, 6);
            send_item(dpdt_pkg::OP_WRITE, sel,
                      ($urandom_range(0, 4) == 0) ? dpdt_pkg::REG_BGLOAD : dpdt_pkg::REG_LOAD,
                      start);
            pick = $urandom_range(0, 9);
            pre  = (pick < 6) ? PRE_DIV1 : (pick < 8) ? PRE_DIV1_ALT :
                   (pick < 9) ? dpdt_pkg::PRE_DIV16 : dpdt_pkg::PRE_DIV256;
            ctrl = BIT_ENABLE | (dpdt_pkg::CTL_W'(pre) << dpdt_pkg::CTL_PRE_LO);
            if ($urandom_range(0, 3) != 0) ctrl |= BIT_INTEN;
            if ($urandom_range(0, 1) != 0) ctrl |= BIT_WIDE;
            if ($urandom_range(0, 7) == 0) ctrl |= ~dpdt_pkg::CTL_WRITABLE;
            case ($urandom_range(0, 2))
               0: ctrl |= BIT_ONESHOT | ($urandom_range(0, 1) ? BIT_PERIODIC : '0);
               1: ctrl |= BIT_PERIODIC;
               default: ;
            endcase
            send_item(dpdt_pkg::OP_WRITE, sel, dpdt_pkg::REG_CTRL, {24'($urandom), ctrl});
            steps = $urandom_range(1, 14);
            repeat (steps) begin
               pick = $urandom_range(0, 9);
               if (pick < 6)
                  send_item(dpdt_pkg::OP_TICK, 1'($urandom_range(0, 1)),
                            dpdt_pkg::REG_W'($urandom_range(0, 7)), $urandom);
               else if (pick < 8)
                  send_item(dpdt_pkg::OP_READ, 1'($urandom_range(0, 1)),
                            dpdt_pkg::REG_W'($urandom_range(0, 7)), $urandom);
               else if (pick == 8)
                  send_item(dpdt_pkg::OP_WRITE, 1'($urandom_range(0, 1)),
                            dpdt_pkg::REG_CLEAR, $urandom);
               else
                  send_item(dpdt_pkg::OP_WRITE, sel, dpdt_pkg::REG_BGLOAD,
                            $urandom_range(0, 6));
            end
         end
      end
   endtask

   // receiver holds off while the sender keeps offering ticks and reads
   task automatic test_backpressure();
      no_idle          = 1'b1;
      hold_off_request = 1'b1;
      repeat (30)
         send_item(($urandom_range(0, 2) == 0) ? dpdt_pkg::OP_READ : dpdt_pkg::OP_TICK,
                   1'($urandom_range(0, 1)), dpdt_pkg::REG_W'($urandom_range(0, 7)),
                   $urandom);
      no_idle = 1'b0;
   endtask

   initial begin
      int t;
      for (t = 0; t < dpdt_pkg::TIMER_SLOTS; t++) begin
         load_reg[t]  = '0;
         count_reg[t] = dpdt_pkg::MASK_WIDE;
         ctrl_reg[t]  = dpdt_pkg::CTL_RESET;
         raw_flag[t]  = 1'b0;
         presc_reg[t] = '0;
      end
      repeat (11) @(posedge clock);
      reset <= 1'b0;

      test_register_map();
      test_expiry_modes();
      test_random_traffic(350);
      no_idle = 1'b1;
      test_random_traffic(500);
      no_idle = 1'b0;
      test_backpressure();
      test_random_traffic(820);
      req_tvalid <= 1'b0;

      // drain, then allow for the pipeline latency
      while (timer_outputs_q.size() != 0) @(posedge clock);
      repeat (4) @(posedge clock);
      if (error_count == 0)
         $display("** dual_periodic_down_timer: PASSED **");
      else
         $display("** dual_periodic_down_timer: FAILED **");
      $finish;
   end

endmodule
